// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge
`define PDH_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent on one edge implies consequent on the next
`define PDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pdh_pkg.sv
`default_nettype none

package pdh_pkg;

  // move status as carried on the result
  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_SETTLED = 2'd1,
    ST_STALL   = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET       = 3'd0,
    REG_GAIN_PROP    = 3'd1,
    REG_GAIN_DERIV   = 3'd2,
    REG_SPEED_LIMIT  = 3'd3,
    REG_SETTLE_BAND  = 3'd4,
    REG_STALL_BAND   = 3'd5,
    REG_SETTLE_TICKS = 3'd6,
    REG_STALL_TICKS  = 3'd7
  } reg_index_t;

  localparam int HEADING_W = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 14;
  localparam int SBAND_W   = 15;
  localparam int TBAND_W   = 16;
  localparam int TICKS_W   = 9;
  localparam int DRIVE_W   = 15;
  localparam int ERR_OUT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST    = 16'd256;
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 14'd16383;
  localparam logic [SBAND_W-1:0] SETTLE_BAND_RST  = 15'd273;
  localparam logic [TBAND_W-1:0] STALL_BAND_RST   = 16'd55;
  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 9'd20;
  localparam logic [TICKS_W-1:0] STALL_TICKS_RST  = 9'd300;

  // outcome of the settle and stall tracking for one item
  typedef struct packed {
    status_t status;
    logic    run;
    logic    track;
  } track_out_t;

endpackage

`default_nettype wire

// File: rtl/core/pdh_track.sv
`default_nettype none

module pdh_track import pdh_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_BITS = 9
) (
  input  wire logic signed [ANGLE_BITS-1:0] err,
  input  wire logic signed [ANGLE_BITS:0]   diff,
  input  wire logic [COUNT_BITS-1:0]        settle_count,
  input  wire logic [COUNT_BITS-1:0]        stall_count,
  input  wire status_t                      status,
  input  wire logic [SBAND_W-1:0]           settle_band,
  input  wire logic signed [TBAND_W-1:0]    stall_band,
  input  wire logic [TICKS_W-1:0]           settle_ticks,
  input  wire logic [TICKS_W-1:0]           stall_ticks,
  output logic [COUNT_BITS-1:0]             settle_count_next,
  output logic [COUNT_BITS-1:0]             stall_count_next,
  output track_out_t                        result
);

  localparam int MW = (ANGLE_BITS > SBAND_W) ? ANGLE_BITS : SBAND_W;
  localparam int DW = ((ANGLE_BITS + 1) > TBAND_W) ? (ANGLE_BITS + 1) : TBAND_W;
  localparam int TW = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [ANGLE_BITS-1:0] mag;
  logic                  in_band;
  logic                  slow;
  logic                  settle_hit;
  logic                  stall_hit;
  logic [COUNT_BITS-1:0] settle_inc;
  logic [COUNT_BITS-1:0] stall_inc;

  // the most negative error wraps to its own magnitude as unsigned
  assign mag     = err[ANGLE_BITS-1] ? (~err + 1'b1) : err;
  assign in_band = MW'(mag) < MW'(settle_band);
  assign slow    = DW'(diff) < DW'(stall_band);

  assign settle_inc = (settle_count == COUNT_MAX) ? settle_count : settle_count + 1'b1;
  assign stall_inc  = (stall_count == COUNT_MAX) ? stall_count : stall_count + 1'b1;

  always_comb begin
    settle_count_next = settle_count;
    stall_count_next  = stall_count;
    result.status     = status;
    result.track      = (status == ST_RUN);
    settle_hit        = 1'b0;
    stall_hit         = 1'b0;
    if (status == ST_RUN) begin
      settle_count_next = in_band ? settle_inc : '0;
      settle_hit        = TW'(settle_count_next) >= TW'(settle_ticks);
      if (settle_hit) begin
        result.status = ST_SETTLED;
      end else begin
        stall_count_next = slow ? stall_inc : '0;
        stall_hit        = TW'(stall_count_next) >= TW'(stall_ticks);
        if (stall_hit) begin
          result.status = ST_STALL;
        end
      end
    end
    result.run = (result.status == ST_RUN);
  end

endmodule

`default_nettype wire

// File: rtl/core/pd_heading_controller.sv
// pd_heading_controller: heading pd loop with settle and stall exit
// path: an item passes the input register, error register, product register
// and result register; the error history closes in the input stage
// throughput: one item per cycle while the output is not stalled
// reset: clears stage valids, error history, counters and status to running,
// and loads every configuration register with its reset value
`default_nettype none

`include "assert_macros.svh"

module pd_heading_controller import pdh_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_BITS = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [HEADING_W-1:0]    s_axis_tdata,  // heading_now
  input  wire logic [0:0]              s_axis_tuser,  // restart
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]        m_axis_tdata,  // motor_drive, move_status,
                                                      // heading_error, zero fill
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  localparam int A   = ANGLE_BITS;
  localparam int HW  = (A > HEADING_W) ? A : HEADING_W;
  localparam int EW  = (A > ERR_OUT_W) ? A : ERR_OUT_W;
  localparam int PPW = A + GAIN_W + 1;
  localparam int PDW = A + GAIN_W + 2;
  localparam int SW  = A + GAIN_W + 3;
  localparam int QW  = SW - 8;

  // configuration
  logic [HEADING_W-1:0]       target_heading;
  logic [GAIN_W-1:0]          gain_prop;
  logic [GAIN_W-1:0]          gain_deriv;
  logic [LIMIT_W-1:0]         speed_limit;
  logic [SBAND_W-1:0]         settle_band;
  logic signed [TBAND_W-1:0]  stall_band;
  logic [TICKS_W-1:0]         settle_ticks;
  logic [TICKS_W-1:0]         stall_ticks;

  // loop state
  logic signed [A-1:0]        last_error;
  logic [COUNT_BITS-1:0]      settle_count;
  logic [COUNT_BITS-1:0]      stall_count;
  status_t                    finish_state;

  // pipeline
  logic                       v1, v2, v3;
  logic                       en1, en2, en3;
  logic                       proc1;
  logic [HEADING_W-1:0]       heading_q;
  logic                       restart_q;

  logic signed [A-1:0]        err2;
  logic                       run2;
  status_t                    status2;
  logic signed [PPW-1:0]      prod_p;
  logic signed [PDW-1:0]      prod_d;

  logic signed [DRIVE_W-1:0]  drive_q;
  status_t                    status_q;
  logic [ERR_OUT_W-1:0]       herr_q;

  // stage 1 logic
  logic signed [A-1:0]        last_eff;
  logic [COUNT_BITS-1:0]      settle_eff;
  logic [COUNT_BITS-1:0]      stall_eff;
  status_t                    status_eff;
  logic [HW-1:0]              err_full;
  logic signed [A-1:0]        err1;
  logic signed [A:0]          diff1;
  logic [COUNT_BITS-1:0]      settle_count_next;
  logic [COUNT_BITS-1:0]      stall_count_next;
  track_out_t                 trk;
  logic signed [A:0]          diff2;

  // stage 3 logic
  logic signed [SW-1:0]       sum;
  logic signed [SW-1:0]       sum_adj;
  logic signed [QW-1:0]       quot;
  logic signed [QW-1:0]       lim_w;
  logic signed [DRIVE_W-1:0]  sat;
  logic signed [DRIVE_W-1:0]  drive_next;
  logic [EW-1:0]              err_ext;

  assign en3   = !v3 || m_axis_tready;
  assign en2   = !v2 || en3;
  assign en1   = !v1 || en2;
  assign proc1 = v1 && en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      gain_prop      <= GAIN_PROP_RST;
      gain_deriv     <= '0;
      speed_limit    <= SPEED_LIMIT_RST;
      settle_band    <= SETTLE_BAND_RST;
      stall_band     <= STALL_BAND_RST;
      settle_ticks   <= SETTLE_TICKS_RST;
      stall_ticks    <= STALL_TICKS_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TARGET:       target_heading <= cfg_data[HEADING_W-1:0];
        REG_GAIN_PROP:    gain_prop      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:   gain_deriv     <= cfg_data[GAIN_W-1:0];
        REG_SPEED_LIMIT:  speed_limit    <= cfg_data[LIMIT_W-1:0];
        REG_SETTLE_BAND:  settle_band    <= cfg_data[SBAND_W-1:0];
        REG_STALL_BAND:   stall_band     <= cfg_data[TBAND_W-1:0];
        REG_SETTLE_TICKS: settle_ticks   <= cfg_data[TICKS_W-1:0];
        REG_STALL_TICKS:  stall_ticks    <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: restart applies before the sample is handled
  always_comb begin
    last_eff   = restart_q ? '0 : last_error;
    settle_eff = restart_q ? '0 : settle_count;
    stall_eff  = restart_q ? '0 : stall_count;
    status_eff = restart_q ? ST_RUN : finish_state;
  end

  assign err_full = HW'(target_heading) - HW'(heading_q);
  assign err1     = err_full[A-1:0];
  assign diff1    = (A+1)'(err1) - (A+1)'(last_eff);

  pdh_track #(
    .ANGLE_BITS(ANGLE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_track (
    .err               (err1),
    .diff              (diff1),
    .settle_count      (settle_eff),
    .stall_count       (stall_eff),
    .status            (status_eff),
    .settle_band       (settle_band),
    .stall_band        (stall_band),
    .settle_ticks      (settle_ticks),
    .stall_ticks       (stall_ticks),
    .settle_count_next (settle_count_next),
    .stall_count_next  (stall_count_next),
    .result            (trk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      last_error   <= '0;
      settle_count <= '0;
      stall_count  <= '0;
      finish_state <= ST_RUN;
    end else begin
      if (en1) begin
        v1 <= s_axis_tvalid;
      end
      if (proc1) begin
        settle_count <= settle_count_next;
        stall_count  <= stall_count_next;
        finish_state <= trk.status;
        last_error   <= trk.track ? err1 : last_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && en1) begin
      heading_q <= s_axis_tdata;
      restart_q <= s_axis_tuser[0];
    end
  end

  // stage 2: error and difference, then products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc1) begin
      err2    <= err1;
      diff2   <= diff1;
      run2    <= trk.run;
      status2 <= trk.status;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && en3) begin
      prod_p <= PPW'(err2) * PPW'($signed({1'b0, gain_prop}));
      prod_d <= PDW'(diff2) * PDW'($signed({1'b0, gain_deriv}));
    end
  end

  // products lag err2 by one stage, so error, run and status move along with them
  logic signed [A-1:0]  err3;
  logic                 run3;
  status_t              status3;
  logic                 v2b;

  always_ff @(posedge clk) begin
    if (v2 && en3) begin
      err3    <= err2;
      run3    <= run2;
      status3 <= status2;
    end
  end

  // stage 3: sum, truncate toward zero, saturate, negate while running, else zero
  assign sum     = SW'(prod_p) + SW'(prod_d);
  assign sum_adj = sum[SW-1] ? (sum + SW'(255)) : sum;
  assign quot    = QW'(sum_adj >>> 8);
  assign lim_w   = QW'({1'b0, speed_limit});

  always_comb begin
    if (quot > lim_w) begin
      sat = DRIVE_W'(lim_w);
    end else if (quot < -lim_w) begin
      sat = DRIVE_W'(-lim_w);
    end else begin
      sat = DRIVE_W'(quot);
    end
    drive_next = run3 ? -sat : '0;
  end

  assign err_ext = EW'(err3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2b <= 1'b0;
      v3  <= 1'b0;
    end else begin
      if (en3) begin
        v2b <= v2;
      end
      if (!v3 || m_axis_tready) begin
        v3 <= v2b && en3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2b && en3) begin
      drive_q  <= drive_next;
      status_q <= status3;
      herr_q   <= err_ext[ERR_OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {{(OUT_DATA_W - DRIVE_W - 2 - ERR_OUT_W){1'b0}},
                          herr_q, status_q, drive_q};

  `PDH_ASSERT_ALWAYS(a_done_zero, !(v3 && status_q != ST_RUN) || drive_q == '0,
    "finished move shows nonzero drive")
  `PDH_ASSERT_NEXT(a_status_hold, finish_state != ST_RUN && !(proc1 && restart_q),
    $stable(finish_state), "finished status changed without restart")
  `PDH_ASSERT_ALWAYS(a_ready_full, s_axis_tready || v1,
    "input stalled with an empty input register")

endmodule

`default_nettype wire
